FILE: rtl/core/bdbw_pkg.sv
// Shared types and constants for the display bus frame writer.
// No dependencies.
`default_nettype none
package bdbw_pkg;
   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   localparam logic [2:0] REG_DEPTH_MODE = 3'd0;
   localparam logic [2:0] REG_PRIMARY    = 3'd1;
   localparam logic [2:0] REG_SECONDARY  = 3'd2;
   localparam logic [2:0] REG_SRC_WIDTH  = 3'd3;
   localparam logic [2:0] REG_SRC_HEIGHT = 3'd4;
   localparam logic [2:0] REG_SCALE      = 3'd5;
   localparam logic [2:0] REG_WRITE_CMD  = 3'd6;

   localparam logic [14:0] UNITY_Q12 = 15'd4096;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int BUF_BYTES  = 8192;

   typedef struct packed {
      logic start;
      logic [7:0] dividend;
      logic [14:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [8:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

FILE: rtl/core/bdbw_divider.sv
// Bit-serial restoring divider: (dividend << 12) / divisor, one quotient bit per cycle.
// Depends on bdbw_pkg.
`default_nettype none
module bdbw_divider
   import bdbw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);
   logic [19:0] num_ff, num_in;
   logic [15:0] rem_ff, rem_in;
   logic [14:0] den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [16:0] trial;

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, num_ff[19]} - {2'b00, den_ff};
      if (req.start) begin
         num_in = {req.dividend, 12'd0};
         den_in = req.divisor;
         rem_in = '0;
         cnt_in = 5'd20;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, keep it as a quotient bit
         if (!trial[16]) begin
            rem_in = trial[15:0];
            num_in = {num_ff[18:0], 1'b1};
         end else begin
            rem_in = {rem_ff[14:0], num_ff[19]};
            num_in = {num_ff[18:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in;
   end

   // quotient never exceeds 255 for the supported scale range; saturate a bit wider
   assign rsp.done = done_ff;
   assign rsp.quotient = (num_ff[19:9] != 11'd0) ? 9'h1FF : num_ff[8:0];
endmodule
`default_nettype wire

FILE: rtl/core/bitmap_to_display_bus_writer.sv
// Frame writer for an eight-bit display bus with nearest-neighbor scaling and 1bpp expansion.
// Depends on bdbw_pkg and bdbw_divider.
//
//   channel | direction | payload
//   req_    | in        | tdata: addr[12:0] data_byte[20:13]; tuser: func[1:0]
//   rsp_    | out       | tdata: bus_byte[7:0]; tuser: dc; tlast: last
//   csr_    | in        | wr_en, index, wdata[15:0]
//
// A load or an ignored beat gives no result. A start raises rsp_tvalid at the accepting
// edge; a raw-mode tick goes through the buffer read, a low-byte tick through S_SEND, and
// a scaled high byte through two serial divides (the second started as the first is done),
// then the address and the buffer read. The next beat is taken in the cycle after the result leaves.
// Synchronous active-high reset clears control state; the buffer is not cleared.
// The next beat is refused while a result waits in the output register.
`default_nettype none
module bitmap_to_display_bus_writer
   import bdbw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // addr[12:0], data_byte[20:13], zero fill
   input  wire logic [1:0]  req_tuser,   // func[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // bus_byte[7:0]
   output logic             rsp_tuser,   // dc
   output logic             rsp_tlast,   // last
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   localparam int AW = $clog2(BUF_BYTES);

   typedef enum logic [2:0] {
      S_IDLE, S_DIVX, S_DIVY, S_ADDR, S_READ, S_SEND
   } state_type;

   logic        depth_ff;
   logic [15:0] prim_ff, sec_ff;
   logic [6:0]  sw_reg_ff, sh_reg_ff;
   logic [14:0] scale_ff;
   logic [7:0]  cmd_ff;

   logic        f_mode_ff, f_raw_ff;
   logic [6:0]  f_w_ff;
   logic [14:0] f_scale_ff;
   logic [8:0]  f_sw_ff, f_sh_ff;
   logic [13:0] f_total_ff;
   logic [8:0]  ox_ff, oy_ff, sx_ff;
   logic [13:0] raw_ff;
   logic        low_ff, active_ff;
   logic [16:0] pix_ff;
   logic [AW-1:0] rd_addr_ff;
   logic        bit_mode_ff;
   logic [2:0]  bit_ff;
   logic        pend_ff;   // read returns next cycle
   state_type   state_ff;

   logic [7:0]  mem [BUF_BYTES];
   logic [7:0]  rd_data_ff;

   logic        rv_ff, rdc_ff, rlast_ff;
   logic [7:0]  rbyte_ff;

   div_req_type dreq;
   div_rsp_type drsp;

   bdbw_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   wire logic [1:0]  func = req_tuser;
   wire logic [12:0] addr = req_tdata[12:0];
   wire logic [7:0]  dbyte = req_tdata[20:13];
   wire logic        accept = req_tvalid && req_tready;

   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rbyte_ff;
   assign rsp_tuser = rdc_ff;
   assign rsp_tlast = rlast_ff;

   // start-time sizes
   logic [6:0]  w_sat, h_sat;
   logic [21:0] sw_prod, sh_prod;
   logic [9:0]  sw_dim, sh_dim;
   always_comb begin
      w_sat = (32'(sw_reg_ff) > MAX_WIDTH)  ? 7'(MAX_WIDTH)  : sw_reg_ff;
      h_sat = (32'(sh_reg_ff) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : sh_reg_ff;
      sw_prod = 22'(w_sat) * 22'(scale_ff);
      sh_prod = 22'(h_sat) * 22'(scale_ff);
      sw_dim = (sw_prod[21:12] > 10'd256) ? 10'd256 : sw_prod[21:12];
      sh_dim = (sh_prod[21:12] > 10'd256) ? 10'd256 : sh_prod[21:12];
   end

   logic [8:0] next_x;
   assign next_x = ox_ff + 9'd1;

   always_comb begin
      dreq.start = 1'b0;
      dreq.dividend = ox_ff[7:0];
      dreq.divisor = f_scale_ff;
      if (state_ff == S_IDLE && accept && func == FUNC_TICK && active_ff
          && !f_raw_ff && !low_ff) begin
         dreq.start = 1'b1;
      end else if (state_ff == S_DIVX && drsp.done) begin
         dreq.start = 1'b1;
         dreq.dividend = oy_ff[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && func == FUNC_LOAD) mem[addr[AW-1:0]] <= dbyte;
      rd_data_ff <= mem[rd_addr_ff];
      if (reset) begin
         depth_ff <= 1'b0; prim_ff <= 16'hFFFF; sec_ff <= '0;
         sw_reg_ff <= 7'd64; sh_reg_ff <= 7'd64; scale_ff <= UNITY_Q12; cmd_ff <= 8'd44;
         state_ff <= S_IDLE; active_ff <= 1'b0; low_ff <= 1'b0;
         rv_ff <= 1'b0; pend_ff <= 1'b0;
         ox_ff <= '0; oy_ff <= '0; raw_ff <= '0;
         f_raw_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_DEPTH_MODE: depth_ff <= csr_wdata[0];
               REG_PRIMARY:    prim_ff <= csr_wdata;
               REG_SECONDARY:  sec_ff <= csr_wdata;
               REG_SRC_WIDTH:  sw_reg_ff <= csr_wdata[6:0];
               REG_SRC_HEIGHT: sh_reg_ff <= csr_wdata[6:0];
               REG_SCALE:      scale_ff <= csr_wdata[14:0];
               REG_WRITE_CMD:  cmd_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept && func == FUNC_START) begin
                  f_mode_ff <= depth_ff;
                  f_w_ff <= w_sat;
                  f_scale_ff <= scale_ff;
                  f_raw_ff <= !depth_ff && scale_ff == UNITY_Q12;
                  f_total_ff <= 14'(w_sat * h_sat * 2);
                  f_sw_ff <= sw_dim[8:0];
                  f_sh_ff <= sh_dim[8:0];
                  ox_ff <= '0; oy_ff <= '0; raw_ff <= '0; low_ff <= 1'b0;
                  rv_ff <= 1'b1; rbyte_ff <= cmd_ff; rdc_ff <= 1'b0;
                  if (!depth_ff && scale_ff == UNITY_Q12) begin
                     active_ff <= (w_sat != 0) && (h_sat != 0);
                     rlast_ff <= (w_sat == 0) || (h_sat == 0);
                  end else begin
                     active_ff <= (sw_dim != 0) && (sh_dim != 0);
                     rlast_ff <= (sw_dim == 0) || (sh_dim == 0);
                  end
               end else if (accept && func == FUNC_TICK && active_ff) begin
                  if (f_raw_ff) begin
                     rd_addr_ff <= raw_ff[AW-1:0];
                     bit_mode_ff <= 1'b0;
                     state_ff <= S_READ; pend_ff <= 1'b1;
                  end else if (low_ff) begin
                     state_ff <= S_SEND;
                  end else begin
                     state_ff <= S_DIVX;
                  end
               end
            end
            S_DIVX: if (drsp.done) begin
               sx_ff <= drsp.quotient;
               state_ff <= S_DIVY;
            end
            S_DIVY: if (drsp.done) begin
               pix_ff <= 17'(drsp.quotient) * 17'(f_w_ff) + 17'(sx_ff);
               state_ff <= S_ADDR;
            end
            S_ADDR: begin
               bit_mode_ff <= f_mode_ff;
               bit_ff <= 3'd7 - pix_ff[2:0];
               if (f_mode_ff) rd_addr_ff <= AW'(pix_ff >> 3);
               else rd_addr_ff <= AW'({pix_ff, 1'b1});
               state_ff <= S_READ; pend_ff <= 1'b1;
            end
            S_READ: if (pend_ff) begin
               pend_ff <= 1'b0;
            end else begin
               if (f_raw_ff) begin
                  rv_ff <= 1'b1; rbyte_ff <= rd_data_ff; rdc_ff <= 1'b1;
                  rlast_ff <= (raw_ff + 14'd1 >= f_total_ff);
                  if (raw_ff + 14'd1 >= f_total_ff) active_ff <= 1'b0;
                  raw_ff <= raw_ff + 14'd1;
                  state_ff <= S_IDLE;
               end else if (bit_mode_ff) begin
                  rv_ff <= 1'b1; rdc_ff <= 1'b1; rlast_ff <= 1'b0;
                  rbyte_ff <= rd_data_ff[bit_ff] ? prim_ff[15:8] : sec_ff[15:8];
                  low_ff <= 1'b1; state_ff <= S_IDLE;
               end else begin
                  rv_ff <= 1'b1; rdc_ff <= 1'b1; rlast_ff <= 1'b0;
                  rbyte_ff <= rd_data_ff;
                  // point at the low byte; the next tick reads it live
                  rd_addr_ff <= AW'({pix_ff, 1'b0});
                  low_ff <= 1'b1; state_ff <= S_IDLE;
               end
            end
            S_SEND: begin
               // live buffer and colors: the read data follows rd_addr_ff every cycle
               rv_ff <= 1'b1; rdc_ff <= 1'b1;
               if (bit_mode_ff) rbyte_ff <= rd_data_ff[bit_ff] ? prim_ff[7:0] : sec_ff[7:0];
               else rbyte_ff <= rd_data_ff;
               rlast_ff <= (next_x >= f_sw_ff) && (oy_ff + 9'd1 >= f_sh_ff);
               if ((next_x >= f_sw_ff) && (oy_ff + 9'd1 >= f_sh_ff)) active_ff <= 1'b0;
               low_ff <= 1'b0;
               if (next_x >= f_sw_ff) begin
                  ox_ff <= '0; oy_ff <= oy_ff + 9'd1;
               end else ox_ff <= next_x;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
